>>> rtl/cft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

   // Fixed field widths of the request, response and control register
   localparam int MODE_W  = 3;
   localparam int FRAME_W = 6;
   localparam int VALUE_W = 21;
   localparam int PROC_W  = 8;
   localparam int VPAGE_W = 21;
   localparam int REF_W   = 2;
   localparam int FIU_W   = 7;

   localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

   // Request modes; the unused code behaves as a read
   localparam logic [MODE_W-1:0] MODE_SET_REF    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_DIRTY  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SET_PROC   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SET_VPAGE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND_EMPTY = 3'd4;
   localparam logic [MODE_W-1:0] MODE_VICTIM     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;

   // Reference states, two-bit two's complement
   localparam logic [REF_W-1:0] REF_NEVER = 2'b11;
   localparam logic [REF_W-1:0] REF_CLEAR = 2'b00;
   localparam logic [REF_W-1:0] REF_SET   = 2'b01;

   localparam logic [VALUE_W-1:0] VALUE_NEG_ONE = '1;

   // Pointer operations
   localparam logic [2:0] PTR_HOLD = 3'd0;
   localparam logic [2:0] PTR_ZERO = 3'd1;
   localparam logic [2:0] PTR_HAND = 3'd2;
   localparam logic [2:0] PTR_INC  = 3'd3;
   localparam logic [2:0] PTR_WRAP = 3'd4;

   // Read address select
   localparam logic RD_FRAME = 1'b0;
   localparam logic RD_PTR   = 1'b1;

   // Response source
   localparam logic [1:0] SRC_MEM    = 2'd0;
   localparam logic [1:0] SRC_VICTIM = 2'd1;
   localparam logic [1:0] SRC_OOR    = 2'd2;
   localparam logic [1:0] SRC_NONE   = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       clear_wr;
      logic       field_wr;
      logic       rd_en;
      logic       rd_sel;
      logic [2:0] ptr_op;
      logic       hand_adv;
      logic       sweep_clr;
      logic       out_load;
      logic [1:0] out_src;
   } cmd_type;

   typedef struct packed {
      logic ptr_lt_n;
      logic clear_last;
      logic rd_vld;
      logic rd_unmapped;
      logic rd_clear;
      logic tag_last;
      logic frame_oor;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/clock_frame_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame table with clock (second-chance) victim selection, one request at a time.
// After reset the table runs a clearing pass over every frame before the first
// request is taken; the frame-count register can be written during it. A read passes
// through the read and result states, a field write through the write, read and result
// states. Find-empty and a victim sweep visit frames in turn, since the table has one
// read port with registered data and each frame visited costs one read. The next request
// is taken in the cycle after the response is loaded, while that response waits in the
// output register.
module clock_frame_table #(
   parameter int MAX_FRAMES   = 64,
   parameter int PROCESS_BITS = 8,
   parameter int VPAGE_BITS   = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [cft_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [cft_pkg::FRAME_W-1:0]        req_frame,
   input  wire logic signed [cft_pkg::VALUE_W-1:0] req_write_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [cft_pkg::FRAME_W-1:0]             rsp_frame_out,
   output logic                                    rsp_found,
   output logic [cft_pkg::PROC_W-1:0]              rsp_process_out,
   output logic signed [cft_pkg::VPAGE_W-1:0]      rsp_virtual_page_out,
   output logic signed [cft_pkg::REF_W-1:0]        rsp_ref_out,
   output logic                                    rsp_dirty_out,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cft_pkg::FIU_W-1:0]          csr_frames_in_use
);

   cft_pkg::cmd_type  cmd;
   cft_pkg::stat_type st;

   cft_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   cft_datapath #(
      .MAX_FRAMES   (MAX_FRAMES),
      .PROCESS_BITS (PROCESS_BITS),
      .VPAGE_BITS   (VPAGE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_mode             (req_mode),
      .req_frame            (req_frame),
      .req_write_value      (req_write_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_frames_in_use    (csr_frames_in_use),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_out        (rsp_frame_out),
      .rsp_found            (rsp_found),
      .rsp_process_out      (rsp_process_out),
      .rsp_virtual_page_out (rsp_virtual_page_out),
      .rsp_ref_out          (rsp_ref_out),
      .rsp_dirty_out        (rsp_dirty_out),
      .cmd                  (cmd),
      .st                   (st)
   );

endmodule

`default_nettype wire

>>> rtl/cft_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cft_datapath #(
   parameter int MAX_FRAMES   = 64,
   parameter int PROCESS_BITS = 8,
   parameter int VPAGE_BITS   = 20
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [cft_pkg::MODE_W-1:0]            req_mode,
   input  wire logic [cft_pkg::FRAME_W-1:0]           req_frame,
   input  wire logic signed [cft_pkg::VALUE_W-1:0]    req_write_value,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cft_pkg::FIU_W-1:0]             csr_frames_in_use,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [cft_pkg::FRAME_W-1:0]                rsp_frame_out,
   output logic                                       rsp_found,
   output logic [cft_pkg::PROC_W-1:0]                 rsp_process_out,
   output logic signed [cft_pkg::VPAGE_W-1:0]         rsp_virtual_page_out,
   output logic signed [cft_pkg::REF_W-1:0]           rsp_ref_out,
   output logic                                       rsp_dirty_out,
   input  wire cft_pkg::cmd_type                      cmd,
   output cft_pkg::stat_type                          st
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int XW    = (CNT_W > cft_pkg::FIU_W) ? CNT_W : cft_pkg::FIU_W;
   localparam int VW    = (VPAGE_BITS > cft_pkg::VALUE_W) ? VPAGE_BITS : cft_pkg::VALUE_W;

   // Captured request
   logic [cft_pkg::MODE_W-1:0]         mode_ff;
   logic [cft_pkg::FRAME_W-1:0]        frame_ff;
   logic signed [cft_pkg::VALUE_W-1:0] value_ff;

   logic [cft_pkg::FIU_W-1:0] fiu_ff;
   logic [CNT_W-1:0]          ptr_ff, ptr_in;
   logic [IDX_W-1:0]          hand_ff, hand_in;
   logic [IDX_W-1:0]          tag_ff;
   logic                      rd_vld_ff;
   logic                      fwd_vld_ff;
   logic [IDX_W-1:0]          fwd_addr_ff;

   // Frame table storage
   logic [PROCESS_BITS-1:0]      proc_mem_ff  [0:MAX_FRAMES-1];
   logic [VPAGE_BITS-1:0]        page_mem_ff  [0:MAX_FRAMES-1];
   logic                         map_mem_ff   [0:MAX_FRAMES-1];
   logic [cft_pkg::REF_W-1:0]    ref_mem_ff   [0:MAX_FRAMES-1];
   logic                         dirty_mem_ff [0:MAX_FRAMES-1];

   logic [PROCESS_BITS-1:0]   rd_proc_ff;
   logic [VPAGE_BITS-1:0]     rd_page_ff;
   logic                      rd_map_ff;
   logic [cft_pkg::REF_W-1:0] rd_ref_ff;
   logic                      rd_dirty_ff;

   logic                      rsp_valid_ff;
   logic [cft_pkg::FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [cft_pkg::PROC_W-1:0]  rsp_proc_ff, rsp_proc_in;
   logic [cft_pkg::VPAGE_W-1:0] rsp_page_ff, rsp_page_in;
   logic [cft_pkg::REF_W-1:0]   rsp_ref_ff, rsp_ref_in;
   logic                        rsp_dirty_ff, rsp_dirty_in;

   logic [XW-1:0]    fiu_x, max_x, n_x, ptr_x, tag_x, frame_x, hand_x;
   logic [IDX_W-1:0] ptr_idx, frame_idx, rd_addr, wr_addr;
   logic             frame_oor, in_rng, csr_acc;
   logic [VW-1:0]    value_ext;
   logic             is_neg_one, is_zero;
   logic             we_proc, we_page, we_map, we_ref, we_dirty;
   logic [PROCESS_BITS-1:0]   d_proc;
   logic                      d_map, d_dirty;
   logic [cft_pkg::REF_W-1:0] d_ref;

   assign csr_ready = !reset;
   assign csr_acc   = csr_valid && csr_ready;

   // Active frame count: zero acts as one, anything above the table size is clamped
   assign fiu_x   = XW'(fiu_ff);
   assign max_x   = XW'(MAX_FRAMES);
   assign n_x     = (fiu_x == '0) ? XW'(1) : ((fiu_x > max_x) ? max_x : fiu_x);
   assign ptr_x   = XW'(ptr_ff);
   assign tag_x   = XW'(tag_ff);
   assign hand_x  = XW'(hand_ff);
   assign frame_x = XW'(frame_ff);

   assign ptr_idx   = ptr_ff[IDX_W-1:0];
   assign frame_idx = frame_x[IDX_W-1:0];
   assign frame_oor = (frame_x >= max_x);
   assign in_rng    = !frame_oor;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         frame_ff <= req_frame;
         value_ff <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= cft_pkg::FIU_RESET;
      end else if (csr_acc) begin
         fiu_ff <= csr_frames_in_use;
      end
   end

   always_comb begin
      case (cmd.ptr_op)
         cft_pkg::PTR_HOLD: ptr_in = ptr_ff;
         cft_pkg::PTR_ZERO: ptr_in = '0;
         cft_pkg::PTR_HAND: ptr_in = (hand_x >= n_x) ? '0 : CNT_W'(hand_ff);
         cft_pkg::PTR_INC:  ptr_in = ptr_ff + CNT_W'(1);
         cft_pkg::PTR_WRAP: ptr_in = ((ptr_x + XW'(1)) >= n_x) ? '0 : ptr_ff + CNT_W'(1);
         default:           ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      hand_in = hand_ff;
      if (csr_acc) begin
         hand_in = '0;
      end else if (cmd.hand_adv) begin
         hand_in = ((tag_x + XW'(1)) >= n_x) ? '0 : IDX_W'(tag_x + XW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         hand_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         hand_ff    <= hand_in;
         rd_vld_ff  <= cmd.rd_en;
         fwd_vld_ff <= cmd.sweep_clr;
      end
   end

   // Remember the frame cleared last cycle: a one-frame sweep rereads it before the write lands
   always_ff @(posedge clock) begin
      if (cmd.sweep_clr) begin
         fwd_addr_ff <= tag_ff;
      end
   end

   // Write port
   assign value_ext  = VW'(value_ff);
   assign is_neg_one = (value_ff == cft_pkg::VALUE_NEG_ONE);
   assign is_zero    = (value_ff == '0);

   assign wr_addr = cmd.clear_wr ? ptr_idx : (cmd.sweep_clr ? tag_ff : frame_idx);

   assign we_proc  = cmd.clear_wr
                     || (cmd.field_wr && in_rng && mode_ff == cft_pkg::MODE_SET_PROC);
   assign we_page  = cmd.field_wr && in_rng && mode_ff == cft_pkg::MODE_SET_VPAGE && !is_neg_one;
   assign we_map   = cmd.clear_wr
                     || (cmd.field_wr && in_rng && mode_ff == cft_pkg::MODE_SET_VPAGE);
   assign we_ref   = cmd.clear_wr || cmd.sweep_clr
                     || (cmd.field_wr && in_rng && mode_ff == cft_pkg::MODE_SET_REF);
   assign we_dirty = cmd.clear_wr
                     || (cmd.field_wr && in_rng && mode_ff == cft_pkg::MODE_SET_DIRTY);

   assign d_proc  = cmd.clear_wr ? '0 : value_ff[PROCESS_BITS-1:0];
   assign d_map   = !cmd.clear_wr && !is_neg_one;
   assign d_dirty = !cmd.clear_wr && !is_zero;

   always_comb begin
      if (cmd.clear_wr) begin
         d_ref = cft_pkg::REF_NEVER;
      end else if (cmd.sweep_clr) begin
         d_ref = cft_pkg::REF_CLEAR;
      end else if (is_neg_one) begin
         d_ref = cft_pkg::REF_NEVER;
      end else if (is_zero) begin
         d_ref = cft_pkg::REF_CLEAR;
      end else begin
         d_ref = cft_pkg::REF_SET;
      end
   end

   // Read port; an out-of-range frame reads entry zero and is masked at the response
   assign rd_addr = (cmd.rd_sel == cft_pkg::RD_PTR) ? ptr_idx : (frame_oor ? '0 : frame_idx);

   always_ff @(posedge clock) begin
      if (we_proc) begin
         proc_mem_ff[wr_addr] <= d_proc;
      end
      if (cmd.rd_en) begin
         rd_proc_ff <= proc_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_page) begin
         page_mem_ff[wr_addr] <= value_ext[VPAGE_BITS-1:0];
      end
      if (cmd.rd_en) begin
         rd_page_ff <= page_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_map) begin
         map_mem_ff[wr_addr] <= d_map;
      end
      if (cmd.rd_en) begin
         rd_map_ff <= map_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_ref) begin
         ref_mem_ff[wr_addr] <= d_ref;
      end
      if (cmd.rd_en) begin
         rd_ref_ff <= ref_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_dirty) begin
         dirty_mem_ff[wr_addr] <= d_dirty;
      end
      if (cmd.rd_en) begin
         rd_dirty_ff <= dirty_mem_ff[rd_addr];
         tag_ff      <= rd_addr;
      end
   end

   // Response register
   always_comb begin
      case (cmd.out_src)
         cft_pkg::SRC_MEM, cft_pkg::SRC_VICTIM: begin
            rsp_frame_in = cft_pkg::FRAME_W'(tag_ff);
            rsp_found_in = 1'b1;
            rsp_proc_in  = cft_pkg::PROC_W'(rd_proc_ff);
            rsp_page_in  = rd_map_ff ? cft_pkg::VPAGE_W'(rd_page_ff) : '1;
            rsp_ref_in   = (cmd.out_src == cft_pkg::SRC_VICTIM) ? cft_pkg::REF_CLEAR : rd_ref_ff;
            rsp_dirty_in = rd_dirty_ff;
         end
         cft_pkg::SRC_OOR: begin
            rsp_frame_in = frame_ff;
            rsp_found_in = 1'b1;
            rsp_proc_in  = '0;
            rsp_page_in  = '1;
            rsp_ref_in   = cft_pkg::REF_NEVER;
            rsp_dirty_in = 1'b0;
         end
         default: begin
            rsp_frame_in = '0;
            rsp_found_in = 1'b0;
            rsp_proc_in  = '0;
            rsp_page_in  = '0;
            rsp_ref_in   = '0;
            rsp_dirty_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_frame_ff <= rsp_frame_in;
         rsp_found_ff <= rsp_found_in;
         rsp_proc_ff  <= rsp_proc_in;
         rsp_page_ff  <= rsp_page_in;
         rsp_ref_ff   <= rsp_ref_in;
         rsp_dirty_ff <= rsp_dirty_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_out        = rsp_frame_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_process_out      = rsp_proc_ff;
   assign rsp_virtual_page_out = rsp_page_ff;
   assign rsp_ref_out          = rsp_ref_ff;
   assign rsp_dirty_out        = rsp_dirty_ff;

   // Status back to the controller
   assign st.ptr_lt_n    = (ptr_x < n_x);
   assign st.clear_last  = (ptr_x == (max_x - XW'(1)));
   assign st.rd_vld      = rd_vld_ff;
   assign st.rd_unmapped = !rd_map_ff;
   assign st.rd_clear    = (rd_ref_ff == cft_pkg::REF_CLEAR)
                           || (fwd_vld_ff && fwd_addr_ff == tag_ff);
   assign st.tag_last    = (tag_x == (n_x - XW'(1)));
   assign st.frame_oor   = frame_oor;
   assign st.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

>>> rtl/cft_control.sv
`timescale 1ns / 1ps
`default_nettype none

module cft_control (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [cft_pkg::MODE_W-1:0] req_mode,
   output logic                            req_ready,
   output cft_pkg::cmd_type                cmd,
   input  wire cft_pkg::stat_type          st
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_SWEEP  = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] src_ff, src_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      src_in    = src_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.ptr_op   = cft_pkg::PTR_INC;
            if (st.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  cft_pkg::MODE_SET_REF, cft_pkg::MODE_SET_DIRTY,
                  cft_pkg::MODE_SET_PROC, cft_pkg::MODE_SET_VPAGE: begin
                     state_in = S_WRITE;
                  end
                  cft_pkg::MODE_FIND_EMPTY: begin
                     cmd.ptr_op = cft_pkg::PTR_ZERO;
                     state_in   = S_SCAN;
                  end
                  cft_pkg::MODE_VICTIM: begin
                     cmd.ptr_op = cft_pkg::PTR_HAND;
                     state_in   = S_SWEEP;
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_WRITE: begin
            cmd.field_wr = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cft_pkg::RD_FRAME;
            src_in     = st.frame_oor ? cft_pkg::SRC_OOR : cft_pkg::SRC_MEM;
            state_in   = S_RESULT;
         end
         S_SCAN: begin
            // one frame issued per cycle; stop issuing on a hit so the read data holds
            if (st.rd_vld && st.rd_unmapped) begin
               src_in   = cft_pkg::SRC_MEM;
               state_in = S_RESULT;
            end else if (st.rd_vld && st.tag_last) begin
               src_in   = cft_pkg::SRC_NONE;
               state_in = S_RESULT;
            end else if (st.ptr_lt_n) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = cft_pkg::RD_PTR;
               cmd.ptr_op = cft_pkg::PTR_INC;
            end
         end
         S_SWEEP: begin
            if (st.rd_vld && st.rd_clear) begin
               cmd.hand_adv = 1'b1;
               src_in       = cft_pkg::SRC_VICTIM;
               state_in     = S_RESULT;
            end else begin
               cmd.sweep_clr = st.rd_vld;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = cft_pkg::RD_PTR;
               cmd.ptr_op    = cft_pkg::PTR_WRAP;
            end
         end
         S_RESULT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = src_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         src_ff   <= cft_pkg::SRC_MEM;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cft_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cft_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [cft_pkg::FRAME_W-1:0]        rsp_frame_out,
   input wire logic                               rsp_found,
   input wire logic [cft_pkg::PROC_W-1:0]         rsp_process_out,
   input wire logic [cft_pkg::VPAGE_W-1:0]        rsp_virtual_page_out,
   input wire logic [cft_pkg::REF_W-1:0]          rsp_ref_out,
   input wire logic                               rsp_dirty_out
);

   logic       req_acc, rsp_acc;
   logic [1:0] pend_ff;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Requests accepted whose response has not yet been taken
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_out) && $stable(rsp_found)
         && $stable(rsp_process_out) && $stable(rsp_virtual_page_out)
         && $stable(rsp_ref_out) && $stable(rsp_dirty_out))
      else $error("response dropped or changed while stalled");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while the previous one is in progress");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_frame_out == '0 && rsp_process_out == '0
         && rsp_virtual_page_out == '0 && rsp_ref_out == '0 && !rsp_dirty_out)
      else $error("find-empty miss carries nonzero fields");

   a_ref_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ref_out != 2'b10)
      else $error("reference state out of range");

endmodule

bind clock_frame_table cft_checker u_cft_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_frame_out        (rsp_frame_out),
   .rsp_found            (rsp_found),
   .rsp_process_out      (rsp_process_out),
   .rsp_virtual_page_out (rsp_virtual_page_out),
   .rsp_ref_out          (rsp_ref_out),
   .rsp_dirty_out        (rsp_dirty_out)
);

`default_nettype wire

>>> tb/sv/clock_frame_table_tb.sv
`timescale 1ns / 1ps

typedef struct {
   logic [cft_pkg::FRAME_W-1:0]        frame_out;
   logic                               found;
   logic [cft_pkg::PROC_W-1:0]         process_out;
   logic signed [cft_pkg::VPAGE_W-1:0] vpage;
   logic signed [cft_pkg::REF_W-1:0]   ref_bits;
   logic                               dirty;
} frame_result_type;

// Shadow copy of the frame table: predicts the response of every accepted request
class frame_table_shadow_type;
   bit [cft_pkg::PROC_W-1:0]  owner    [64];
   bit [19:0]                 page     [64];
   bit                        mapped   [64];
   logic [cft_pkg::REF_W-1:0] ref_st   [64];
   bit                        dirty    [64];
   int unsigned               hand;
   int unsigned               frame_count;
   frame_result_type          owed_replies [$];
   frame_result_type          last_result;
   int                        mismatches;
   int                        responses_checked;

   function void clear_table();
      for (int i = 0; i < 64; i++) begin
         owner[i]  = '0;
         page[i]   = '0;
         mapped[i] = 1'b0;
         ref_st[i] = cft_pkg::REF_NEVER;
         dirty[i]  = 1'b0;
      end
      hand = 0;
      frame_count = cft_pkg::FIU_RESET;
      mismatches = 0;
      responses_checked = 0;
   endfunction

   function void set_frame_count(logic [cft_pkg::FIU_W-1:0] value);
      frame_count = value;
      hand = 0;
   endfunction

   // Zero behaves as one frame, anything above the table size as the full table
   function int unsigned active();
      if (frame_count == 0) return 1;
      if (frame_count > 64) return 64;
      return frame_count;
   endfunction

   function int pending();
      return owed_replies.size();
   endfunction

   function frame_result_type view(int unsigned f, bit hit);
      frame_result_type r;
      r.frame_out   = f[cft_pkg::FRAME_W-1:0];
      r.found       = hit;
      r.process_out = owner[f];
      r.vpage       = mapped[f] ? {1'b0, page[f]} : cft_pkg::VALUE_NEG_ONE;
      r.ref_bits    = ref_st[f];
      r.dirty       = dirty[f];
      return r;
   endfunction

   function void take_request(logic [cft_pkg::MODE_W-1:0] mode,
                              logic [cft_pkg::FRAME_W-1:0] frame,
                              logic signed [cft_pkg::VALUE_W-1:0] value);
      frame_result_type r;
      int unsigned      n;
      int unsigned      h;
      int unsigned      visits;
      bit               done;
      n = active();
      done = 1'b0;
      case (mode)
         cft_pkg::MODE_SET_REF: begin
            if (value == cft_pkg::VALUE_NEG_ONE) ref_st[frame] = cft_pkg::REF_NEVER;
            else if (value == 0) ref_st[frame] = cft_pkg::REF_CLEAR;
            else ref_st[frame] = cft_pkg::REF_SET;
            r = view(frame, 1'b1);
         end
         cft_pkg::MODE_SET_DIRTY: begin
            dirty[frame] = (value != 0);
            r = view(frame, 1'b1);
         end
         cft_pkg::MODE_SET_PROC: begin
            owner[frame] = value[cft_pkg::PROC_W-1:0];
            r = view(frame, 1'b1);
         end
         cft_pkg::MODE_SET_VPAGE: begin
            if (value == cft_pkg::VALUE_NEG_ONE) begin
               mapped[frame] = 1'b0;
            end else begin
               page[frame] = value[19:0];
               mapped[frame] = 1'b1;
            end
            r = view(frame, 1'b1);
         end
         cft_pkg::MODE_FIND_EMPTY: begin
            r.frame_out = '0;
            r.found = 1'b0;
            r.process_out = '0;
            r.vpage = '0;
            r.ref_bits = '0;
            r.dirty = 1'b0;
            h = 0;
            while (!done && h < n) begin
               if (!mapped[h]) begin
                  r = view(h, 1'b1);
                  done = 1'b1;
               end
               h++;
            end
         end
         cft_pkg::MODE_VICTIM: begin
            if (hand >= n) hand = 0;
            visits = 0;
            // give every referenced or untouched frame a second chance
            while (!done && visits <= n) begin
               h = hand;
               hand = (h + 1 >= n) ? 0 : h + 1;
               if (ref_st[h] == cft_pkg::REF_CLEAR) begin
                  r = view(h, 1'b1);
                  done = 1'b1;
               end else begin
                  ref_st[h] = cft_pkg::REF_CLEAR;
               end
               visits++;
            end
            if (!done) r = view(hand, 1'b1);
         end
         default: r = view(frame, 1'b1);
      endcase
      last_result = r;
      owed_replies.push_back(r);
   endfunction

   function void match_field(string field, logic signed [31:0] want_v,
                             logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatches++;
      end
   endfunction

   function void check_response(frame_result_type got);
      frame_result_type want;
      if (owed_replies.size() == 0) begin
         $error("response for frame %0d with no request outstanding", got.frame_out);
         mismatches++;
         return;
      end
      want = owed_replies.pop_front();
      responses_checked++;
      match_field("frame_out", want.frame_out, got.frame_out);
      match_field("found", want.found, got.found);
      match_field("process_out", want.process_out, got.process_out);
      match_field("virtual_page_out", want.vpage, got.vpage);
      match_field("ref_out", want.ref_bits, got.ref_bits);
      match_field("dirty_out", want.dirty, got.dirty);
   endfunction
endclass

module clock_frame_table_tb;

   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 205;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [cft_pkg::MODE_W-1:0]         req_mode = cft_pkg::MODE_READ;
   logic [cft_pkg::FRAME_W-1:0]        req_frame = '0;
   logic signed [cft_pkg::VALUE_W-1:0] req_write_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [cft_pkg::FRAME_W-1:0]        rsp_frame_out;
   logic                               rsp_found;
   logic [cft_pkg::PROC_W-1:0]         rsp_process_out;
   logic signed [cft_pkg::VPAGE_W-1:0] rsp_virtual_page_out;
   logic signed [cft_pkg::REF_W-1:0]   rsp_ref_out;
   logic                               rsp_dirty_out;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [cft_pkg::FIU_W-1:0]          csr_frames_in_use = cft_pkg::FIU_RESET;

   frame_table_shadow_type shadow;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int settings_used = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit hold_pending = 1'b0;

   logic [cft_pkg::FIU_W-1:0] frame_settings [8] =
      '{7'd64, 7'd8, 7'd1, 7'd33, 7'd0, 7'd127, 7'd3, 7'd65};

   clock_frame_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_frame(req_frame),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_out(rsp_frame_out),
      .rsp_found(rsp_found),
      .rsp_process_out(rsp_process_out),
      .rsp_virtual_page_out(rsp_virtual_page_out),
      .rsp_ref_out(rsp_ref_out),
      .rsp_dirty_out(rsp_dirty_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_frames_in_use(csr_frames_in_use)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      frame_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.frame_out   = rsp_frame_out;
         got.found       = rsp_found;
         got.process_out = rsp_process_out;
         got.vpage       = rsp_virtual_page_out;
         got.ref_bits    = rsp_ref_out;
         got.dirty       = rsp_dirty_out;
         shadow.check_response(got);
      end
   end

   // Receiver: random stalls, or a long hold-off once asked for
   always @(posedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function logic signed [cft_pkg::VALUE_W-1:0] pick_value();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(5))
         0: return cft_pkg::VALUE_NEG_ONE;
         1: return '0;
         2: return 21'd1;
         3: return 21'h0FFFFF;
         4: return 21'h100000;
         default: return raw[cft_pkg::VALUE_W-1:0];
      endcase
   endfunction

   task send_item(input logic [cft_pkg::MODE_W-1:0] mode,
                  input logic [cft_pkg::FRAME_W-1:0] frame,
                  input logic signed [cft_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_frame <= frame;
      req_write_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.take_request(mode, frame, value);
      items_sent++;
   endtask

   // Drop valid and wait for every outstanding response
   task settle();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   task write_frame_count(input logic [cft_pkg::FIU_W-1:0] value);
      csr_valid <= 1'b1;
      csr_frames_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.set_frame_count(value);
      settings_used++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Page fault: take an unmapped frame, else evict one, then map it afresh
   task send_fault();
      logic [cft_pkg::FRAME_W-1:0] target;
      logic [31:0]                 raw;
      raw = $urandom;
      send_item(cft_pkg::MODE_FIND_EMPTY, raw[5:0], pick_value());
      if (!shadow.last_result.found)
         send_item(cft_pkg::MODE_VICTIM, raw[11:6], pick_value());
      target = shadow.last_result.frame_out;
      send_item(cft_pkg::MODE_SET_VPAGE, target,
                cft_pkg::VALUE_W'($urandom_range(20'hFFFFF, 0)));
      send_item(cft_pkg::MODE_SET_PROC, target, pick_value());
      send_item(cft_pkg::MODE_SET_REF, target, 21'd1);
      if ($urandom_range(1)) send_item(cft_pkg::MODE_SET_DIRTY, target, pick_value());
   endtask

   task run_random(input int count);
      int                          stop_at;
      int                          pick;
      logic [cft_pkg::FRAME_W-1:0] f;
      logic [31:0]                 raw;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         f = cft_pkg::FRAME_W'($urandom_range(shadow.active() - 1, 0));
         raw = $urandom;
         if (pick < 30) send_fault();
         else if (pick < 42) send_item(cft_pkg::MODE_SET_REF, f, pick_value());
         else if (pick < 50) send_item(cft_pkg::MODE_SET_VPAGE, f, cft_pkg::VALUE_NEG_ONE);
         else if (pick < 62) send_item(cft_pkg::MODE_VICTIM, f, pick_value());
         else if (pick < 70) send_item(cft_pkg::MODE_FIND_EMPTY, f, pick_value());
         else if (pick < 80) send_item(cft_pkg::MODE_READ, f, pick_value());
         else send_item(raw[2:0], raw[8:3], pick_value());
      end
   endtask

   task run_directed();
      send_item(cft_pkg::MODE_READ, 6'd0, '0);
      send_item(cft_pkg::MODE_FIND_EMPTY, 6'd9, '0);
      // untouched table: the sweep clears every frame and comes back to the first
      send_item(cft_pkg::MODE_VICTIM, 6'd0, '0);
      send_item(cft_pkg::MODE_SET_REF, 6'd63, cft_pkg::VALUE_NEG_ONE);
      send_item(cft_pkg::MODE_SET_REF, 6'd5, 21'h0FFFFF);
      send_item(cft_pkg::MODE_SET_REF, 6'd6, 21'h100000);
      send_item(cft_pkg::MODE_SET_REF, 6'd7, '0);
      send_item(cft_pkg::MODE_SET_DIRTY, 6'd63, 21'h100000);
      send_item(cft_pkg::MODE_SET_DIRTY, 6'd62, 21'd1);
      send_item(cft_pkg::MODE_SET_PROC, 6'd63, 21'h0FFFFF);
      send_item(cft_pkg::MODE_SET_PROC, 6'd1, 21'h000155);
      send_item(cft_pkg::MODE_SET_VPAGE, 6'd0, 21'h0FFFFF);
      send_item(cft_pkg::MODE_SET_VPAGE, 6'd1, -21'sd2);
      send_item(cft_pkg::MODE_SET_VPAGE, 6'd2, 21'h100000);
      send_item(cft_pkg::MODE_FIND_EMPTY, 6'd0, '0);
      send_item(cft_pkg::MODE_SET_VPAGE, 6'd0, cft_pkg::VALUE_NEG_ONE);
      send_item(cft_pkg::MODE_FIND_EMPTY, 6'd0, '0);
      send_item(3'd7, 6'd1, '0);
      send_item(cft_pkg::MODE_VICTIM, 6'd0, '0);
      settle();
      write_frame_count(7'd1);
      send_item(cft_pkg::MODE_SET_VPAGE, 6'd0, 21'd5);
      // single managed frame, already mapped: nothing free
      send_item(cft_pkg::MODE_FIND_EMPTY, 6'd0, '0);
      send_item(cft_pkg::MODE_SET_REF, 6'd0, 21'd1);
      send_item(cft_pkg::MODE_VICTIM, 6'd0, '0);
      settle();
      write_frame_count(7'd0);
      send_item(cft_pkg::MODE_VICTIM, 6'd40, '0);
      send_item(cft_pkg::MODE_READ, 6'd63, '0);
   endtask

   initial begin
      shadow = new;
      shadow.clear_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < 8; p++) begin
         settle();
         write_frame_count(frame_settings[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         // hold the response side off so the block backs up into the request side
         if (p % 4 == 0) hold_pending = 1'b1;
         run_random(PHASE_ITEMS);
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests over %0d frame-count settings, %0d responses checked",
               items_sent, settings_used, shadow.responses_checked);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("All tests passed");
      end else begin
         if (shadow.pending() != 0) $error("%0d responses never arrived", shadow.pending());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/cft_pkg.sv
rtl/cft_datapath.sv
rtl/cft_control.sv
rtl/clock_frame_table.sv
rtl/cft_checker.sv
tb/sv/clock_frame_table_tb.sv
